/* src/pwch_pkg.sv */
// Shared types, sizes and helper functions for the photon window count histogram.
// No dependencies; the front end, queue, histogram side and top level import this package.
package pwch_pkg;

	localparam int HIST_DIM     = 64;
	localparam int NUM_CHANNELS = 64;
	localparam int BUCKET_W     = 32;

	localparam int IDX_W      = (HIST_DIM > 1) ? $clog2(HIST_DIM) : 1;
	localparam int PAIR_DEPTH = HIST_DIM * HIST_DIM;
	localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
	localparam int TOT_AW     = IDX_W;

	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ITEM_PHOTON   = 2'd0,
		ITEM_CLOSE    = 2'd1,
		ITEM_RD_PAIR  = 2'd2,
		ITEM_RD_TOTAL = 2'd3
	} item_kind_t;

	typedef enum logic [1:0] {
		RES_VERDICT = 2'd0,
		RES_PAIR    = 2'd1,
		RES_TOTAL   = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		REG_CH1_MASK = 2'd0,
		REG_CH2_MASK = 2'd1,
		REG_MIN      = 2'd2,
		REG_MAX      = 2'd3
	} reg_sel_t;

	typedef struct packed {
		logic [63:0] ch1_mask;
		logic [63:0] ch2_mask;
		logic [5:0]  min_photons;
		logic [5:0]  max_photons;
	} cfg_t;

	// One queued operation for the histogram side
	typedef struct packed {
		res_kind_t          kind;
		logic               accepted;
		logic               zero_read;
		logic [CNT_W-1:0]   n1;
		logic [CNT_W-1:0]   n2;
		logic [31:0]        start;
		logic [31:0]        stop;
		logic [PAIR_AW-1:0] pair_addr;
		logic [TOT_AW-1:0]  tot_addr;
	} op_t;

	function automatic logic [BUCKET_W-1:0] cell_sat_inc(input logic [BUCKET_W-1:0] v);
		logic [BUCKET_W-1:0] r;
		r = (v == '1) ? v : v + 1'b1;
		return r;
	endfunction

	// Clamp a cell to the 32-bit read-out field
	function automatic logic [31:0] cell_report(input logic [BUCKET_W-1:0] v);
		logic [BUCKET_W+31:0] wide;
		logic [BUCKET_W+31:0] lim;
		logic [31:0]          r;
		wide = {32'b0, v};
		lim  = {{BUCKET_W{1'b0}}, 32'hFFFF_FFFF};
		r    = (wide > lim) ? 32'hFFFF_FFFF : wide[31:0];
		return r;
	endfunction

endpackage

/* src/pwch_ram.sv */
// Generic single-write, single-read memory with registered read data.
// Read during a write to the same address returns the old content.
module pwch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/pwch_front.sv */
// Front end: accepts items, keeps the running channel counts, classifies items
// and pushes window verdicts and cell reads as operations. Uses pwch_pkg.
module pwch_front import pwch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        item_fire,
	input  logic [1:0]  kind,
	input  logic [5:0]  channel,
	input  logic [31:0] window_start,
	input  logic [31:0] window_stop,
	input  logic [5:0]  row_index,
	input  logic [5:0]  col_index,
	output logic        push,
	output op_t         push_op
);

	logic [CNT_W-1:0] cnt_one_q;
	logic [CNT_W-1:0] cnt_two_q;
	logic [CNT_W:0]   total;
	logic             chan_ok;
	logic             hit_one;
	logic             hit_two;
	logic             win_ok;
	logic             row_ok;
	logic             col_ok;
	item_kind_t       kind_e;

	assign kind_e  = item_kind_t'(kind);
	assign chan_ok = int'(channel) < NUM_CHANNELS;
	assign hit_one = chan_ok && cfg.ch1_mask[channel];
	assign hit_two = chan_ok && cfg.ch2_mask[channel];
	assign total   = {1'b0, cnt_one_q} + {1'b0, cnt_two_q};
	assign win_ok  = (total >= (CNT_W+1)'(cfg.min_photons))
		&& (total <= (CNT_W+1)'(cfg.max_photons))
		&& (int'(total) < HIST_DIM);
	assign row_ok  = int'(row_index) < HIST_DIM;
	assign col_ok  = int'(col_index) < HIST_DIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_one_q <= '0;
			cnt_two_q <= '0;
		end else if (item_fire) begin
			case (kind_e)
				ITEM_PHOTON: begin
					if (hit_one && cnt_one_q != CNT_MAX) cnt_one_q <= cnt_one_q + 1'b1;
					if (hit_two && cnt_two_q != CNT_MAX) cnt_two_q <= cnt_two_q + 1'b1;
				end
				ITEM_CLOSE: begin
					cnt_one_q <= '0;
					cnt_two_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		push_op = '0;
		push    = item_fire && (kind_e != ITEM_PHOTON);
		unique case (kind_e)
			ITEM_PHOTON: begin
			end
			ITEM_CLOSE: begin
				push_op.kind      = RES_VERDICT;
				push_op.accepted  = win_ok;
				push_op.n1        = cnt_one_q;
				push_op.n2        = cnt_two_q;
				push_op.start     = window_start;
				push_op.stop      = window_stop;
				push_op.pair_addr = PAIR_AW'(int'(cnt_one_q) * HIST_DIM + int'(cnt_two_q));
				push_op.tot_addr  = TOT_AW'(total);
			end
			ITEM_RD_PAIR: begin
				push_op.kind      = RES_PAIR;
				push_op.zero_read = !(row_ok && col_ok);
				push_op.pair_addr = PAIR_AW'(int'(row_index) * HIST_DIM + int'(col_index));
			end
			ITEM_RD_TOTAL: begin
				push_op.kind      = RES_TOTAL;
				push_op.zero_read = !row_ok;
				push_op.tot_addr  = TOT_AW'(row_index);
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/pwch_queue.sv */
// Short operation queue between the front end and the histogram side.
// Flop storage, one push and one pop per cycle. Uses pwch_pkg.
module pwch_queue import pwch_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/pwch_back.sv */
// Histogram side: clears both histograms after reset, runs read-modify-write
// with forwarding, and holds the result register. Uses pwch_pkg and pwch_ram.
module pwch_back import pwch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  op_t         q_op,
	output logic        q_pop,
	output logic        clearing,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic        accepted,
	output logic [7:0]  count_one,
	output logic [7:0]  count_two,
	output logic [31:0] start_out,
	output logic [31:0] stop_out,
	output logic [31:0] cell_value
);

	logic                 clr_q;
	logic [PAIR_AW-1:0]   clr_cnt_q;

	logic                 valid_s2;
	op_t                  op_s2;

	logic                 pfwd_v_q;
	logic [PAIR_AW-1:0]   pfwd_addr_q;
	logic [BUCKET_W-1:0]  pfwd_data_q;
	logic                 tfwd_v_q;
	logic [TOT_AW-1:0]    tfwd_addr_q;
	logic [BUCKET_W-1:0]  tfwd_data_q;

	logic                 res_valid_q;
	logic [1:0]           res_kind_q;
	logic                 accepted_q;
	logic [7:0]           count_one_q;
	logic [7:0]           count_two_q;
	logic [31:0]          start_q;
	logic [31:0]          stop_q;
	logic [31:0]          cell_q;

	logic [BUCKET_W-1:0]  pair_rdata;
	logic [BUCKET_W-1:0]  tot_rdata;
	logic [BUCKET_W-1:0]  pair_cur;
	logic [BUCKET_W-1:0]  tot_cur;
	logic [BUCKET_W-1:0]  pair_new;
	logic [BUCKET_W-1:0]  tot_new;
	logic                 fire;
	logic                 bump;
	logic                 pair_we;
	logic [PAIR_AW-1:0]   pair_waddr;
	logic [BUCKET_W-1:0]  pair_wdata;
	logic                 tot_we;
	logic [TOT_AW-1:0]    tot_waddr;
	logic [BUCKET_W-1:0]  tot_wdata;
	logic [31:0]          cell_next;

	assign clearing = clr_q;
	assign fire     = valid_s2 && (!res_valid_q || result_ready);
	assign q_pop    = q_valid && !clr_q && (!valid_s2 || fire);
	assign bump     = fire && (op_s2.kind == RES_VERDICT) && op_s2.accepted;

	// Take the last write when it hit the address read at the same edge
	assign pair_cur = (pfwd_v_q && pfwd_addr_q == op_s2.pair_addr) ? pfwd_data_q : pair_rdata;
	assign tot_cur  = (tfwd_v_q && tfwd_addr_q == op_s2.tot_addr) ? tfwd_data_q : tot_rdata;
	assign pair_new = cell_sat_inc(pair_cur);
	assign tot_new  = cell_sat_inc(tot_cur);

	assign pair_we    = clr_q || bump;
	assign pair_waddr = clr_q ? clr_cnt_q : op_s2.pair_addr;
	assign pair_wdata = clr_q ? '0 : pair_new;
	assign tot_we     = (clr_q && int'(clr_cnt_q) < HIST_DIM) || bump;
	assign tot_waddr  = clr_q ? TOT_AW'(clr_cnt_q) : op_s2.tot_addr;
	assign tot_wdata  = clr_q ? '0 : tot_new;

	pwch_ram #(
		.WIDTH (BUCKET_W),
		.DEPTH (PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.re    (q_pop),
		.raddr (q_op.pair_addr),
		.rdata (pair_rdata)
	);

	pwch_ram #(
		.WIDTH (BUCKET_W),
		.DEPTH (HIST_DIM)
	) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_waddr),
		.wdata (tot_wdata),
		.re    (q_pop),
		.raddr (q_op.tot_addr),
		.rdata (tot_rdata)
	);

	always_comb begin
		case (op_s2.kind)
			RES_PAIR:  cell_next = op_s2.zero_read ? 32'd0 : cell_report(pair_cur);
			RES_TOTAL: cell_next = op_s2.zero_read ? 32'd0 : cell_report(tot_cur);
			default:   cell_next = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s2    <= 1'b0;
			pfwd_v_q    <= 1'b0;
			tfwd_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == PAIR_AW'(PAIR_DEPTH - 1)) clr_q <= 1'b0;
			end
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (bump) begin
				pfwd_v_q <= 1'b1;
				tfwd_v_q <= 1'b1;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s2 <= q_op;
		end
		if (bump) begin
			pfwd_addr_q <= op_s2.pair_addr;
			pfwd_data_q <= pair_new;
			tfwd_addr_q <= op_s2.tot_addr;
			tfwd_data_q <= tot_new;
		end
		if (fire) begin
			res_kind_q  <= op_s2.kind;
			accepted_q  <= op_s2.accepted;
			count_one_q <= op_s2.n1;
			count_two_q <= op_s2.n2;
			start_q     <= op_s2.start;
			stop_q      <= op_s2.stop;
			cell_q      <= cell_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign accepted     = accepted_q;
	assign count_one    = count_one_q;
	assign count_two    = count_two_q;
	assign start_out    = start_q;
	assign stop_out     = stop_q;
	assign cell_value   = cell_q;

endmodule

/* src/photon_window_count_histogram_core.sv */
// Top level of the photon window count histogram: configuration registers and
// the front end, queue and histogram side. Uses pwch_pkg and the pwch modules.
//
// Usage: after reset the block zeroes the pair histogram, one cell per cycle
// (the total histogram is zeroed with the first 64 of them), and item_ready
// stays low during that pass. Afterwards it takes one item per cycle while
// the queue is not full: photons only update the running counts, while window
// closes and cell reads travel through a four-entry queue to the histogram
// side, which does a read-modify-write on memories with one write port and one
// registered read port, with forwarding of the last write. A verdict or cell
// value passes from the queue through the read stage to the result register,
// and a held result stalls only the histogram side until the queue fills.
// Registers sit at byte addresses 0, 8, 16 and 24.
module photon_window_count_histogram_core import pwch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  channel,
	input  logic [31:0] window_start,
	input  logic [31:0] window_stop,
	input  logic [5:0]  row_index,
	input  logic [5:0]  col_index,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic        accepted,
	output logic [7:0]  count_one,
	output logic [7:0]  count_two,
	output logic [31:0] start_out,
	output logic [31:0] stop_out,
	output logic [31:0] cell_value
);

	logic [63:0]    ch1_q;
	logic [63:0]    ch2_q;
	logic [5:0]     min_q;
	logic [5:0]     max_q;
	reg_sel_t       reg_sel;
	logic           reg_wr;
	cfg_t           cfg;
	logic           item_fire;
	logic           q_push;
	op_t            q_push_op;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	op_t            q_head;
	logic           clearing;
	logic [CNT_W:0] res_total;

	assign pready  = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[4:3]);
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch1_q <= '0;
			ch2_q <= '0;
			min_q <= '0;
			max_q <= 6'd63;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_CH1_MASK: ch1_q <= pwdata;
				REG_CH2_MASK: ch2_q <= pwdata;
				REG_MIN:      min_q <= pwdata[5:0];
				REG_MAX:      max_q <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CH1_MASK: prdata = ch1_q;
			REG_CH2_MASK: prdata = ch2_q;
			REG_MIN:      prdata = {58'b0, min_q};
			REG_MAX:      prdata = {58'b0, max_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.ch1_mask    = ch1_q;
	assign cfg.ch2_mask    = ch2_q;
	assign cfg.min_photons = min_q;
	assign cfg.max_photons = max_q;

	assign item_ready = !clearing && !q_full;
	assign item_fire  = item_valid && item_ready;

	pwch_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_fire    (item_fire),
		.kind         (kind),
		.channel      (channel),
		.window_start (window_start),
		.window_stop  (window_stop),
		.row_index    (row_index),
		.col_index    (col_index),
		.push         (q_push),
		.push_op      (q_push_op)
	);

	pwch_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_push_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_op    (q_head)
	);

	pwch_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_head),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.accepted     (accepted),
		.count_one    (count_one),
		.count_two    (count_two),
		.start_out    (start_out),
		.stop_out     (stop_out),
		.cell_value   (cell_value)
	);

	assign res_total = {1'b0, count_one} + {1'b0, count_two};

	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item_ready)
		else $error("item taken while histograms are being cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("operation pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == RES_VERDICT && accepted) |->
		(res_total >= (CNT_W+1)'(min_q) && res_total <= (CNT_W+1)'(max_q)))
		else $error("accepted window total outside the photon limits");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !clearing)
		else $error("histogram access during the clearing pass");

endmodule

/* tb/sv/tb_photon_window_count_histogram_core.sv */
// Self-checking testbench for photon_window_count_histogram_core.
// Holds a scoreboard class with its own window/histogram predictor; depends on pwch_pkg.
module tb_photon_window_count_histogram_core import pwch_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 12000;
	localparam int MAX_PRINTED    = 100;

	typedef struct packed {
		res_kind_t   kind;
		logic        accepted;
		logic [7:0]  n1;
		logic [7:0]  n2;
		logic [31:0] start;
		logic [31:0] stop;
		logic [31:0] cell_val;
	} hist_result_t;

	class window_hist_scoreboard;
		logic [63:0]         ch1_mask;
		logic [63:0]         ch2_mask;
		logic [5:0]          min_ph;
		logic [5:0]          max_ph;
		logic [7:0]          run_one;
		logic [7:0]          run_two;
		logic [BUCKET_W-1:0] pair_cells [PAIR_DEPTH];
		logic [BUCKET_W-1:0] total_cells [HIST_DIM];
		hist_result_t        due_results [$];
		int                  errors;

		function new();
			ch1_mask = '0;
			ch2_mask = '0;
			min_ph   = 6'd0;
			max_ph   = 6'd63;
			run_one  = '0;
			run_two  = '0;
			errors   = 0;
			foreach (pair_cells[i]) pair_cells[i] = '0;
			foreach (total_cells[i]) total_cells[i] = '0;
		endfunction

		function void set_register(input int idx, input logic [63:0] v);
			case (idx)
				REG_CH1_MASK: ch1_mask = v;
				REG_CH2_MASK: ch2_mask = v;
				REG_MIN:      min_ph = v[5:0];
				REG_MAX:      max_ph = v[5:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function logic [BUCKET_W-1:0] bump(input logic [BUCKET_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// clamp wide bins to the 32-bit read-out
		function logic [31:0] clamp_cell(input logic [BUCKET_W-1:0] v);
			logic [63:0] wide;
			wide = 64'(v);
			return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
		endfunction

		function void note_item(input item_kind_t k, input logic [5:0] chan,
				input logic [31:0] start, input logic [31:0] stop,
				input logic [5:0] row, input logic [5:0] col);
			hist_result_t r;
			int total;
			bit ok;
			r = '0;
			case (k)
				ITEM_PHOTON: begin
					if (int'(chan) < NUM_CHANNELS) begin
						if (ch1_mask[chan] && run_one != 8'hFF) run_one++;
						if (ch2_mask[chan] && run_two != 8'hFF) run_two++;
					end
					return;
				end
				ITEM_CLOSE: begin
					total = int'(run_one) + int'(run_two);
					ok = total >= int'(min_ph) && total <= int'(max_ph) && total < HIST_DIM;
					if (ok) begin
						pair_cells[int'(run_one) * HIST_DIM + int'(run_two)] =
							bump(pair_cells[int'(run_one) * HIST_DIM + int'(run_two)]);
						total_cells[total] = bump(total_cells[total]);
					end
					r.kind     = RES_VERDICT;
					r.accepted = ok;
					r.n1       = run_one;
					r.n2       = run_two;
					r.start    = start;
					r.stop     = stop;
					run_one = '0;
					run_two = '0;
				end
				ITEM_RD_PAIR: begin
					r.kind = RES_PAIR;
					if (int'(row) < HIST_DIM && int'(col) < HIST_DIM)
						r.cell_val = clamp_cell(pair_cells[int'(row) * HIST_DIM + int'(col)]);
				end
				default: begin
					r.kind = RES_TOTAL;
					if (int'(row) < HIST_DIM) r.cell_val = clamp_cell(total_cells[int'(row)]);
				end
			endcase
			due_results = {due_results, r};
		endfunction

		task report_mismatch(input string msg);
			if (errors < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(input hist_result_t got);
			hist_result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with nothing pending", got.kind));
				return;
			end
			want = due_results.pop_front();
			if (got.kind != want.kind)
				report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
			if (got.accepted != want.accepted)
				report_mismatch($sformatf("accepted %0d, want %0d", got.accepted, want.accepted));
			if (got.n1 != want.n1)
				report_mismatch($sformatf("count_one %0d, want %0d", got.n1, want.n1));
			if (got.n2 != want.n2)
				report_mismatch($sformatf("count_two %0d, want %0d", got.n2, want.n2));
			if (got.start != want.start)
				report_mismatch($sformatf("start_out %h, want %h", got.start, want.start));
			if (got.stop != want.stop)
				report_mismatch($sformatf("stop_out %h, want %h", got.stop, want.stop));
			if (got.cell_val != want.cell_val)
				report_mismatch($sformatf("cell_value %0d, want %0d",
					got.cell_val, want.cell_val));
		endtask
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [4:0]  paddr        = '0;
	logic [63:0] pwdata       = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	logic [1:0]  kind         = '0;
	logic [5:0]  channel      = '0;
	logic [31:0] window_start = '0;
	logic [31:0] window_stop  = '0;
	logic [5:0]  row_index    = '0;
	logic [5:0]  col_index    = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  result_kind;
	logic        accepted;
	logic [7:0]  count_one;
	logic [7:0]  count_two;
	logic [31:0] start_out;
	logic [31:0] stop_out;
	logic [31:0] cell_value;

	window_hist_scoreboard sb = new();

	bit gaps_on = 1'b1;
	int items_sent = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	photon_window_count_histogram_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.channel      (channel),
		.window_start (window_start),
		.window_stop  (window_stop),
		.row_index    (row_index),
		.col_index    (col_index),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.accepted     (accepted),
		.count_one    (count_one),
		.count_two    (count_two),
		.start_out    (start_out),
		.stop_out     (stop_out),
		.cell_value   (cell_value)
	);

	always #5 clk = ~clk;

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 6) == 0) begin
			result_ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hist_result_t seen;
		if (arst_n && result_valid && result_ready) begin
			seen.kind     = res_kind_t'(result_kind);
			seen.accepted = accepted;
			seen.n1       = count_one;
			seen.n2       = count_two;
			seen.start    = start_out;
			seen.stop     = stop_out;
			seen.cell_val = cell_value;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_photon_window_count_histogram_core: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input int idx, input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx * 8);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(idx, v);
	endtask

	task automatic set_config(input logic [63:0] m1, input logic [63:0] m2,
			input logic [5:0] lo, input logic [5:0] hi);
		write_reg(REG_CH1_MASK, m1);
		write_reg(REG_CH2_MASK, m2);
		write_reg(REG_MIN, 64'(lo));
		write_reg(REG_MAX, 64'(hi));
	endtask

	// hold off until every expected result is back, then let in-flight photons settle
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_item(input item_kind_t k, input logic [5:0] ch,
			input logic [31:0] st, input logic [31:0] sp,
			input logic [5:0] r, input logic [5:0] c);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid   <= 1'b1;
		kind         <= k;
		channel      <= ch;
		window_start <= st;
		window_stop  <= sp;
		row_index    <= r;
		col_index    <= c;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sb.note_item(k, ch, st, sp, r, c);
		items_sent++;
	endtask

	// bias indices toward the small counts that windows actually reach
	task automatic send_read();
		logic [5:0] r;
		logic [5:0] c;
		r = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 12)) : 6'($urandom);
		c = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 8)) : 6'($urandom);
		if ($urandom_range(0, 1) != 0)
			send_item(ITEM_RD_PAIR, 6'($urandom), $urandom, $urandom, r, c);
		else
			send_item(ITEM_RD_TOTAL, 6'($urandom), $urandom, $urandom, r, c);
	endtask

	task automatic send_window(input int len);
		repeat (len) begin
			if ($urandom_range(0, 9) == 0) send_read();
			send_item(ITEM_PHOTON, 6'($urandom), $urandom, $urandom,
				6'($urandom), 6'($urandom));
		end
		send_item(ITEM_CLOSE, 6'($urandom), $urandom, $urandom, 6'($urandom), 6'($urandom));
	endtask

	task automatic run_windows(input int n);
		int stop_at;
		int pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				if ($urandom_range(0, 7) == 0)
					send_window($urandom_range(11, 70));
				else
					send_window($urandom_range(0, 10));
			end else if (pick < 92) begin
				send_read();
			end else begin
				send_item(item_kind_t'($urandom_range(0, 3)), 6'($urandom), $urandom,
					$urandom, 6'($urandom), 6'($urandom));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config('1, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 6'd63);
		// cleared histograms, empty window, channel extremes, index extremes
		send_item(ITEM_RD_PAIR, 6'd0, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_RD_TOTAL, 6'd0, 32'd0, 32'd0, 6'd63, 6'd0);
		send_item(ITEM_RD_PAIR, 6'd0, 32'd0, 32'd0, 6'd63, 6'd63);
		send_item(ITEM_CLOSE, 6'd0, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_PHOTON, 6'd0, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_PHOTON, 6'd63, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_PHOTON, 6'd1, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_RD_TOTAL, 6'd0, 32'd0, 32'd0, 6'd0, 6'd0);
		send_item(ITEM_CLOSE, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0);
		send_item(ITEM_RD_PAIR, 6'd0, 32'd0, 32'd0, 6'd3, 6'd2);
		send_item(ITEM_RD_TOTAL, 6'd0, 32'd0, 32'd0, 6'd5, 6'd0);
		send_item(ITEM_CLOSE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, 6'd0);
		send_item(ITEM_RD_PAIR, 6'd0, 32'd0, 32'd0, 6'd0, 6'd0);
		wait_drained();

		set_config({$urandom, $urandom}, {$urandom, $urandom}, 6'd2, 6'd6);
		run_windows(50);
		wait_drained();

		// min above max: every window is rejected
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 6'd40, 6'd5);
		run_windows(30);
		wait_drained();

		set_config('0, '1, 6'd63, 6'd63);
		send_window(63);
		run_windows(20);
		wait_drained();

		set_config('0, '0, 6'd0, 6'd0);
		run_windows(20);
		wait_drained();

		// both counts run into saturation
		set_config('1, '1, 6'd0, 6'd63);
		send_window(260);
		run_windows(20);
		wait_drained();

		set_config({$urandom, $urandom}, {$urandom, $urandom},
			6'($urandom_range(0, 10)), 6'($urandom_range(10, 63)));
		run_windows(50);
		gaps_on = 1'b0;
		run_windows(50);

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("tb_photon_window_count_histogram_core: PASS");
		else
			$display("tb_photon_window_count_histogram_core: FAIL");
		$finish;
	end

endmodule
